// ----- design/rwc_pkg.sv -----
// Shared constants and types of the RGB window convolution filter.
// Used by the top level and by the channel divider; depends on nothing.
package rwc_pkg;

	localparam int MAX_WIDTH_DEF   = 2048;
	localparam int WINDOW_SIZE_DEF = 5;
	localparam int ROW_SLOTS       = 8;
	localparam int SLOT_W          = 3;
	localparam int MIN_SIZE        = 5;
	localparam int MAX_HEIGHT      = 4096;
	localparam int ROW_W           = 12;
	localparam int HEIGHT_W        = 13;
	localparam int SUM_W           = 21;
	localparam int TOT_W           = 13;
	localparam int PADDR_W         = 6;

	localparam logic [2:0] REG_TAPS_LOW  = 3'd0;
	localparam logic [2:0] REG_TAPS_MID  = 3'd1;
	localparam logic [2:0] REG_TAPS_HIGH = 3'd2;
	localparam logic [2:0] REG_LAST_TAP  = 3'd3;
	localparam logic [2:0] REG_FIVE      = 3'd4;
	localparam logic [2:0] REG_WIDTH     = 3'd5;
	localparam logic [2:0] REG_HEIGHT    = 3'd6;

	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] sum;
		logic signed [TOT_W-1:0] tot;
	} div_req_t;

endpackage

// ----- design/rwc_div.sv -----
// Bit-serial rounding divider with clamp for one color channel.
// Depends on rwc_pkg for the request struct and the sum widths.
module rwc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rwc_pkg::div_req_t req,
	output logic              done,
	output logic [7:0]        result
);

	localparam int NUM_W = 24;
	localparam int DEN_W = 14;
	localparam logic [3:0] LAST_STEP = 4'd8;
	localparam logic [3:0] FINISH    = 4'd9;

	logic                            busy_q;
	logic [3:0]                      cnt_q;
	logic                            zero_q;
	logic                            neg_q;
	logic                            sat_q;
	logic signed [rwc_pkg::SUM_W-1:0] sum_q;
	logic signed [NUM_W-1:0]         num_q;
	logic [DEN_W-1:0]                den_q;
	logic [NUM_W-1:0]                rem_q;
	logic [NUM_W-1:0]                dsh_q;
	logic [7:0]                      quo_q;
	logic                            done_q;
	logic [7:0]                      result_q;

	logic signed [rwc_pkg::SUM_W:0] sabs_c;
	logic signed [rwc_pkg::TOT_W:0] tabs_c;
	logic signed [NUM_W-1:0]        num_c;
	logic [DEN_W-1:0]               den_c;
	logic                           ge_c;

	function automatic logic [7:0] clamp8(input logic signed [rwc_pkg::SUM_W-1:0] v);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	always_comb begin
		// A negative tap sum flips both signs so the divisor is positive.
		if (req.tot < 0) begin
			sabs_c = -((rwc_pkg::SUM_W+1)'(req.sum));
			tabs_c = -((rwc_pkg::TOT_W+1)'(req.tot));
		end else begin
			sabs_c = (rwc_pkg::SUM_W+1)'(req.sum);
			tabs_c = (rwc_pkg::TOT_W+1)'(req.tot);
		end
		num_c = (NUM_W'(sabs_c) <<< 1) + NUM_W'(tabs_c);
		den_c = DEN_W'(tabs_c) << 1;
		ge_c  = rem_q >= dsh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				zero_q <= (req.tot == '0);
				sum_q  <= req.sum;
				num_q  <= num_c;
				den_q  <= den_c;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == '0) begin
					neg_q <= num_q < 0;
					sat_q <= $unsigned(num_q) >= (NUM_W'(den_q) << 8);
					rem_q <= $unsigned(num_q);
					dsh_q <= NUM_W'(den_q) << 7;
					quo_q <= '0;
				end else if (cnt_q <= LAST_STEP) begin
					if (ge_c) begin
						rem_q <= rem_q - dsh_q;
					end
					quo_q <= {quo_q[6:0], ge_c};
					dsh_q <= dsh_q >> 1;
				end else if (cnt_q == FINISH) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					if (zero_q) begin
						result_q <= clamp8(sum_q);
					end else if (neg_q) begin
						result_q <= 8'd0;
					end else if (sat_q) begin
						result_q <= 8'd255;
					end else begin
						result_q <= quo_q;
					end
				end
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- design/rgb_window_convolution_filter.sv -----
// Top level of the RGB window convolution filter: line store, window
// sequencer, register port. Depends on rwc_pkg and rwc_div.
//
// Pixels come in on the input channel in raster order, one item each, and
// leave filtered on the output channel; an item is moved when valid is high
// and stall is low. A drain item carries no pixel and pushes out one pending
// pixel of a completed frame. Outputs trail the inputs by 2*W+2 pixels.
// An input item that releases a border pixel runs ST_PREP, ST_PASS and
// ST_OUT; one that releases a filtered pixel runs ST_PREP, ST_READ,
// ST_FLUSH, ST_DIV and ST_OUT. The single read port of the line store
// fetches the 25 window pixels one per cycle, and the divider resolves one
// quotient bit per cycle. The finished pixel sits in an output register,
// so the next item is taken while the receiver stalls; the sequencer only
// waits when a second result is ready before the first has been taken.
// After reset the line store is cleared, one entry per cycle, over all
// ROW_SLOTS*MAX_WIDTH entries (16384 at the default width); input stalls in
// that time while register writes are taken as usual. The register port
// is APB-style with 64-bit data; registers sit at byte address 8*index.
module rgb_window_convolution_filter #(
	parameter int MAX_WIDTH   = rwc_pkg::MAX_WIDTH_DEF,
	parameter int WINDOW_SIZE = rwc_pkg::WINDOW_SIZE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  red_in,
	input  logic [7:0]                  green_in,
	input  logic [7:0]                  blue_in,
	input  logic                        drain,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  red_out,
	output logic [7:0]                  green_out,
	output logic [7:0]                  blue_out,
	output logic                        frame_done,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rwc_pkg::PADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);

	localparam int DEPTH = rwc_pkg::ROW_SLOTS * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CB    = $clog2(MAX_WIDTH);
	localparam int SB    = rwc_pkg::SLOT_W;
	localparam int RB    = rwc_pkg::ROW_W;
	localparam int HB    = rwc_pkg::HEIGHT_W;
	localparam int SW    = rwc_pkg::SUM_W;
	localparam int TW    = rwc_pkg::TOT_W;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_PREP, ST_PASS, ST_READ, ST_FLUSH, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [63:0] taps_low_q, taps_mid_q, taps_high_q;
	logic [7:0]  last_tap_q;
	logic        five_q;
	logic [11:0] fwidth_q;
	logic [12:0] fheight_q;

	// Positions of the next input pixel and of the next output pixel.
	logic [WW-1:0]  col_q, ocol_q;
	logic [RB-1:0]  row_q, orow_q;
	logic [SB-1:0]  slot_q, oslot_q;
	logic [15:0]    pend_q;
	logic [AW-1:0]  clr_q;
	logic [2:0]     r_q, c_q;
	logic           fdone_q;

	logic [23:0]    mem [DEPTH];
	logic [23:0]    rd_q;
	logic           wr_en;
	logic [AW-1:0]  wr_addr, rd_addr;
	logic [23:0]    wr_data;

	logic                 rdv_s1, v_s2;
	logic signed [7:0]    tap_s1, tap_s2;
	logic signed [16:0]   pr_s2, pg_s2, pb_s2;
	logic signed [SW-1:0] acc_r_q, acc_g_q, acc_b_q;
	logic signed [TW-1:0] tot_q;
	logic [7:0]           res_r_q, res_g_q, res_b_q;
	logic                 ov_q;
	logic [7:0]           or_q, og_q, ob_q;
	logic                 ofd_q;

	logic [WW-1:0]  w;
	logic [HB-1:0]  h;
	logic           acc_in, cfg_wr;
	logic [15:0]    pend_inc;
	logic [16:0]    thr;
	logic           emit_px, emit_dr;
	logic           in_col_last, in_row_last, o_col_last, o_row_last;
	logic           pass;
	logic           big;
	logic signed [7:0] taps [25];
	logic signed [7:0] tap_cur;
	logic [SB-1:0]  wslot;
	logic [CB-1:0]  wcol;
	logic           div_start;
	logic           done_r, done_g, done_b;
	logic [7:0]     q_r, q_g, q_b;
	rwc_pkg::div_req_t req_r, req_g, req_b;

	function automatic logic [AW-1:0] addr_of(input logic [SB-1:0] s, input logic [CB-1:0] c);
		return AW'(s) * AW'(MAX_WIDTH) + AW'(c);
	endfunction

	// ---------------------------------------------------------------- registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_low_q  <= '0;
			taps_mid_q  <= '0;
			taps_high_q <= '0;
			last_tap_q  <= '0;
			five_q      <= 1'b1;
			fwidth_q    <= 12'd640;
			fheight_q   <= 13'd480;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				rwc_pkg::REG_TAPS_LOW:  taps_low_q  <= pwdata;
				rwc_pkg::REG_TAPS_MID:  taps_mid_q  <= pwdata;
				rwc_pkg::REG_TAPS_HIGH: taps_high_q <= pwdata;
				rwc_pkg::REG_LAST_TAP:  last_tap_q  <= pwdata[7:0];
				rwc_pkg::REG_FIVE:      five_q      <= pwdata[0];
				rwc_pkg::REG_WIDTH:     fwidth_q    <= pwdata[11:0];
				rwc_pkg::REG_HEIGHT:    fheight_q   <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			rwc_pkg::REG_TAPS_LOW:  prdata = taps_low_q;
			rwc_pkg::REG_TAPS_MID:  prdata = taps_mid_q;
			rwc_pkg::REG_TAPS_HIGH: prdata = taps_high_q;
			rwc_pkg::REG_LAST_TAP:  prdata = {56'd0, last_tap_q};
			rwc_pkg::REG_FIVE:      prdata = {63'd0, five_q};
			rwc_pkg::REG_WIDTH:     prdata = {52'd0, fwidth_q};
			rwc_pkg::REG_HEIGHT:    prdata = {51'd0, fheight_q};
			default:                prdata = '0;
		endcase
	end

	// Frame size, held inside the supported range.
	always_comb begin
		if (fwidth_q < 12'(rwc_pkg::MIN_SIZE)) begin
			w = WW'(rwc_pkg::MIN_SIZE);
		end else if (int'(fwidth_q) > MAX_WIDTH) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(fwidth_q);
		end
		if (fheight_q < 13'(rwc_pkg::MIN_SIZE)) begin
			h = HB'(rwc_pkg::MIN_SIZE);
		end else if (fheight_q > 13'(rwc_pkg::MAX_HEIGHT)) begin
			h = HB'(rwc_pkg::MAX_HEIGHT);
		end else begin
			h = fheight_q;
		end
	end

	// Kernel taps, unpacked; the 3x3 kernel uses the first nine in the center.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			taps[i]      = taps_low_q[8*i +: 8];
			taps[i + 8]  = taps_mid_q[8*i +: 8];
			taps[i + 16] = taps_high_q[8*i +: 8];
		end
		taps[24] = last_tap_q;
	end

	assign big = five_q && (WINDOW_SIZE >= 5);

	always_comb begin
		if (big) begin
			tap_cur = taps[5'(r_q) * 5'd5 + 5'(c_q)];
		end else if (r_q >= 3'd1 && r_q <= 3'd3 && c_q >= 3'd1 && c_q <= 3'd3) begin
			tap_cur = taps[(5'(r_q) - 5'd1) * 5'd3 + 5'(c_q) - 5'd1];
		end else begin
			tap_cur = '0;
		end
	end

	// ---------------------------------------------------------------- positions
	assign in_stall = (state_q != ST_IDLE);
	assign acc_in   = in_valid && !in_stall;

	assign in_col_last = (WW+1)'(col_q) + 1'b1 >= (WW+1)'(w);
	assign in_row_last = HB'(row_q) + 1'b1 >= h;
	assign o_col_last  = (WW+1)'(ocol_q) + 1'b1 >= (WW+1)'(w);
	assign o_row_last  = HB'(orow_q) + 1'b1 >= h;

	assign pend_inc = (pend_q == 16'hFFFF) ? pend_q : pend_q + 16'd1;
	assign thr      = (17'(w) << 1) + 17'd2;
	assign emit_px  = {1'b0, pend_inc} > thr;
	assign emit_dr  = (col_q == '0) && (row_q == '0) && (pend_q != '0);

	// Pixels near any frame edge bypass the kernel.
	assign pass = (ocol_q < WW'(2)) || ((WW+1)'(ocol_q) + 2'd2 >= (WW+1)'(w))
		|| (orow_q < RB'(2)) || (HB'(orow_q) + 2'd2 >= h);

	// ---------------------------------------------------------------- line store
	assign wslot = oslot_q + SB'(r_q) + SB'(rwc_pkg::ROW_SLOTS - 2);
	assign wcol  = ocol_q[CB-1:0] + CB'(c_q) - CB'(2);

	always_comb begin
		wr_en   = (state_q == ST_CLEAR) || (acc_in && !drain);
		wr_addr = (state_q == ST_CLEAR) ? clr_q : addr_of(slot_q, col_q[CB-1:0]);
		wr_data = (state_q == ST_CLEAR) ? 24'd0 : {red_in, green_in, blue_in};
		rd_addr = (state_q == ST_PREP) ? addr_of(oslot_q, ocol_q[CB-1:0])
			: addr_of(wslot, wcol);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// ---------------------------------------------------------------- MAC pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1 <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			rdv_s1 <= (state_q == ST_READ);
			v_s2   <= rdv_s1;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1 <= tap_cur;
		tap_s2 <= tap_s1;
		pr_s2  <= $signed({1'b0, rd_q[23:16]}) * tap_s1;
		pg_s2  <= $signed({1'b0, rd_q[15:8]}) * tap_s1;
		pb_s2  <= $signed({1'b0, rd_q[7:0]}) * tap_s1;
		if (state_q == ST_PREP) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
			tot_q   <= '0;
		end else if (v_s2) begin
			acc_r_q <= acc_r_q + SW'(pr_s2);
			acc_g_q <= acc_g_q + SW'(pg_s2);
			acc_b_q <= acc_b_q + SW'(pb_s2);
			tot_q   <= tot_q + TW'(tap_s2);
		end
	end

	// ---------------------------------------------------------------- dividers
	assign div_start = (state_q == ST_FLUSH) && !rdv_s1 && !v_s2;

	always_comb begin
		req_r = '{start: div_start, sum: acc_r_q, tot: tot_q};
		req_g = '{start: div_start, sum: acc_g_q, tot: tot_q};
		req_b = '{start: div_start, sum: acc_b_q, tot: tot_q};
	end

	rwc_div u_div_r (.clk(clk), .arst_n(arst_n), .req(req_r), .done(done_r), .result(q_r));
	rwc_div u_div_g (.clk(clk), .arst_n(arst_n), .req(req_g), .done(done_g), .result(q_g));
	rwc_div u_div_b (.clk(clk), .arst_n(arst_n), .req(req_b), .done(done_b), .result(q_b));

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			slot_q  <= '0;
			ocol_q  <= '0;
			orow_q  <= '0;
			oslot_q <= '0;
			pend_q  <= '0;
			r_q     <= '0;
			c_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			// In ST_OUT the output register is handled by the state itself.
			if (ov_q && !out_stall && state_q != ST_OUT) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc_in) begin
						if (!drain) begin
							pend_q <= pend_inc;
							if (in_col_last) begin
								col_q  <= '0;
								slot_q <= slot_q + 1'b1;
								row_q  <= in_row_last ? '0 : row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
							if (emit_px) begin
								state_q <= ST_PREP;
							end
						end else if (emit_dr) begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					fdone_q <= o_col_last && o_row_last;
					r_q     <= '0;
					c_q     <= '0;
					state_q <= pass ? ST_PASS : ST_READ;
				end
				ST_PASS: begin
					res_r_q <= rd_q[23:16];
					res_g_q <= rd_q[15:8];
					res_b_q <= rd_q[7:0];
					state_q <= ST_OUT;
				end
				ST_READ: begin
					if (c_q == 3'd4) begin
						c_q <= '0;
						r_q <= r_q + 3'd1;
						if (r_q == 3'd4) begin
							state_q <= ST_FLUSH;
						end
					end else begin
						c_q <= c_q + 3'd1;
					end
				end
				ST_FLUSH: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (done_r && done_g && done_b) begin
						res_r_q <= q_r;
						res_g_q <= q_g;
						res_b_q <= q_b;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!ov_q || !out_stall) begin
						ov_q  <= 1'b1;
						or_q  <= res_r_q;
						og_q  <= res_g_q;
						ob_q  <= res_b_q;
						ofd_q <= fdone_q;
						if (pend_q != '0) begin
							pend_q <= pend_q - 16'd1;
						end
						if (o_col_last) begin
							ocol_q  <= '0;
							oslot_q <= oslot_q + 1'b1;
							orow_q  <= o_row_last ? '0 : orow_q + 1'b1;
						end else begin
							ocol_q <= ocol_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign red_out    = or_q;
	assign green_out  = og_q;
	assign blue_out   = ob_q;
	assign frame_done = ofd_q;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the RGB window convolution filter: raster pixel
// stimulus, APB register setup and a local model of the filter.
// Depends on rwc_pkg and the rgb_window_convolution_filter RTL.
module tb;

	localparam int LINE_MAX   = rwc_pkg::MAX_WIDTH_DEF;
	localparam int ITEM_GOAL  = 1950;
	localparam int CYCLE_CAP  = 1000000;
	localparam int SETTLE_CYC = 60;
	localparam int HOLD_CYC   = 400;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       done;
	} pixel_t;

	// Clock and reset.
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Pixel input channel.
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] red_in = '0;
	logic [7:0] green_in = '0;
	logic [7:0] blue_in = '0;
	logic       drain = 1'b0;

	// Pixel output channel.
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       frame_done;

	// Register port.
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [rwc_pkg::PADDR_W-1:0] paddr = '0;
	logic [63:0]                 pwdata = '0;
	logic [63:0]                 prdata;
	logic                        pready;

	rgb_window_convolution_filter uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in), .drain(drain),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.frame_done(frame_done),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Bookkeeping shared by the test tasks and the output checker.
	int     errors = 0;
	int     items_sent = 0;
	int     pixels_checked = 0;
	int     cycles = 0;
	bit     quiet = 1'b0;
	logic   hold_on = 1'b0;
	event   hold_go;
	pixel_t filtered_q[$];

	// Shadow copy of the register file, at reset values.
	logic [63:0] tap_words[3] = '{64'd0, 64'd0, 64'd0};
	logic [7:0]  tap_last = 8'd0;
	logic        use_5x5 = 1'b1;
	logic [11:0] width_reg = 12'd640;
	logic [12:0] height_reg = 13'd480;

	// Local copy of the line store and the raster positions.
	logic [23:0] line_mem[0:rwc_pkg::ROW_SLOTS*LINE_MAX-1];
	int in_col = 0, in_row = 0, in_slot = 0;
	int out_col = 0, out_row = 0, out_slot = 0;
	int backlog = 0;

	initial begin
		for (int i = 0; i < rwc_pkg::ROW_SLOTS*LINE_MAX; i++) line_mem[i] = '0;
	end

	function automatic int tap_value(int i);
		logic [7:0] b;
		if (i >= 24) b = tap_last;
		else b = tap_words[i/8][8*(i%8) +: 8];
		return int'($signed(b));
	endfunction

	function automatic int active_width();
		if (width_reg < rwc_pkg::MIN_SIZE) return rwc_pkg::MIN_SIZE;
		if (width_reg > LINE_MAX) return LINE_MAX;
		return int'(width_reg);
	endfunction

	function automatic int active_height();
		if (height_reg < rwc_pkg::MIN_SIZE) return rwc_pkg::MIN_SIZE;
		if (height_reg > rwc_pkg::MAX_HEIGHT) return rwc_pkg::MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	// Division rounded to nearest, halves going toward plus infinity.
	function automatic int div_round(int s, int t);
		int num, den, q;
		if (t < 0) begin
			s = -s;
			t = -t;
		end
		num = 2*s + t;
		den = 2*t;
		q = num / den;
		if ((num % den) != 0 && num < 0) q--;
		return q;
	endfunction

	function automatic logic [7:0] sat8(int v);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	function automatic void step_raster(inout int col, inout int row, inout int slot,
			input int w, input int h);
		if (col + 1 >= w) begin
			col = 0;
			slot = (slot + 1) % rwc_pkg::ROW_SLOTS;
			row = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			col = col + 1;
		end
	endfunction

	// Produces the next output pixel at the output raster position.
	function automatic pixel_t filter_pixel(int w, int h);
		pixel_t o;
		logic [23:0] p;
		int sr, sg, sb, tot, t, r, c, s;
		sr = 0; sg = 0; sb = 0; tot = 0;
		if (out_col < 2 || out_col + 2 >= w || out_row < 2 || out_row + 2 >= h) begin
			p = line_mem[out_slot*LINE_MAX + out_col % LINE_MAX];
			o.red = p[23:16];
			o.green = p[15:8];
			o.blue = p[7:0];
		end else begin
			for (int k = 0; k < 25; k++) begin
				r = k / 5;
				c = k % 5;
				if (use_5x5) begin
					t = tap_value(k);
				end else begin
					if (r < 1 || r > 3 || c < 1 || c > 3) continue;
					t = tap_value((r-1)*3 + (c-1));
				end
				s = (out_slot + r - 2 + rwc_pkg::ROW_SLOTS) % rwc_pkg::ROW_SLOTS;
				p = line_mem[s*LINE_MAX + (out_col + c - 2) % LINE_MAX];
				tot += t;
				sr += int'(p[23:16]) * t;
				sg += int'(p[15:8]) * t;
				sb += int'(p[7:0]) * t;
			end
			if (tot == 0) begin
				o.red = sat8(sr);
				o.green = sat8(sg);
				o.blue = sat8(sb);
			end else begin
				o.red = sat8(div_round(sr, tot));
				o.green = sat8(div_round(sg, tot));
				o.blue = sat8(div_round(sb, tot));
			end
		end
		o.done = (out_col + 1 >= w && out_row + 1 >= h);
		step_raster(out_col, out_row, out_slot, w, h);
		if (backlog > 0) backlog--;
		return o;
	endfunction

	// Advances the model by one accepted item; returns 1 when it yields a pixel.
	function automatic bit predict_item(logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic d, output pixel_t o);
		int w, h;
		w = active_width();
		h = active_height();
		o = '0;
		if (!d) begin
			line_mem[in_slot*LINE_MAX + in_col % LINE_MAX] = {r, g, b};
			step_raster(in_col, in_row, in_slot, w, h);
			if (backlog < 16'hFFFF) backlog++;
			if (backlog > 2*w + 2) begin
				o = filter_pixel(w, h);
				return 1'b1;
			end
			return 1'b0;
		end
		// A drain only pushes out the tail of a completed frame.
		if (in_col == 0 && in_row == 0 && backlog > 0) begin
			o = filter_pixel(w, h);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report(string msg);
		errors++;
		$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d predictions open", cycles,
				filtered_q.size());
			$display("rgb_window_convolution_filter verification failed");
			$finish;
		end
	end

	// The receiver stalls now and then, and for a long stretch on request.
	always @(posedge clk) begin
		out_stall <= hold_on || (!quiet && $urandom_range(99) < 9);
	end

	initial begin
		forever begin
			@(hold_go);
			@(posedge clk);
			hold_on <= 1'b1;
			repeat (HOLD_CYC) @(posedge clk);
			hold_on <= 1'b0;
		end
	end

	// Output values are captured mid-cycle, so the edge that moves an item
	// sees them settled and free of any ordering race.
	logic   out_taken = 1'b0;
	pixel_t out_seen;

	always @(negedge clk) begin
		out_taken = out_valid && !out_stall;
		out_seen = '{red_out, green_out, blue_out, frame_done};
	end

	always @(posedge clk) begin
		pixel_t e;
		if (out_taken) begin
			if (filtered_q.size() == 0) begin
				report("output pixel arrived with no prediction waiting");
			end else begin
				e = filtered_q.pop_front();
				pixels_checked++;
				if (out_seen.red !== e.red)
					report($sformatf("red %0d, expected %0d", out_seen.red, e.red));
				if (out_seen.green !== e.green)
					report($sformatf("green %0d, expected %0d", out_seen.green, e.green));
				if (out_seen.blue !== e.blue)
					report($sformatf("blue %0d, expected %0d", out_seen.blue, e.blue));
				if (out_seen.done !== e.done)
					report($sformatf("frame_done %0b, expected %0b", out_seen.done, e.done));
			end
		end
	end

	// Offers one item and returns at the edge that accepts it, valid left high.
	task automatic send_item(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic d);
		pixel_t o;
		bit stalled;
		if (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		drain <= d;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		items_sent++;
		if (predict_item(r, g, b, d, o)) filtered_q.push_back(o);
	endtask

	task automatic send_pixel();
		logic [7:0] c[3];
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(7))
				0: c[i] = 8'd0;
				1: c[i] = 8'd255;
				default: c[i] = 8'($urandom_range(255));
			endcase
		end
		send_item(c[0], c[1], c[2], 1'b0);
	endtask

	// Pushes out the tail of a completed frame, plus one drain with nothing left.
	task automatic flush_frame();
		while (in_col == 0 && in_row == 0 && backlog > 0)
			send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)), 1'b1);
		send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 1'b1);
	endtask

	// Lowers valid and waits until every predicted pixel has come out and the
	// pipeline has had time to finish any item still in flight.
	task automatic settle();
		in_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			rwc_pkg::REG_TAPS_LOW:  tap_words[0] = v;
			rwc_pkg::REG_TAPS_MID:  tap_words[1] = v;
			rwc_pkg::REG_TAPS_HIGH: tap_words[2] = v;
			rwc_pkg::REG_LAST_TAP:  tap_last = v[7:0];
			rwc_pkg::REG_FIVE:      use_5x5 = v[0];
			rwc_pkg::REG_WIDTH:     width_reg = v[11:0];
			rwc_pkg::REG_HEIGHT:    height_reg = v[12:0];
			default: ;
		endcase
	endtask

	task automatic send_frames(int n);
		for (int i = 0; i < n * active_width() * active_height(); i++) send_pixel();
	endtask

	// Box filter on a minimal frame with extreme colors, then a 3x3 kernel
	// with a negative tap sum, then a zero tap sum that skips the division.
	task automatic test_directed();
		reg_write(rwc_pkg::REG_TAPS_LOW, 64'h0101_0101_0101_0101);
		reg_write(rwc_pkg::REG_TAPS_MID, 64'h0101_0101_0101_0101);
		reg_write(rwc_pkg::REG_TAPS_HIGH, 64'h0101_0101_0101_0101);
		reg_write(rwc_pkg::REG_LAST_TAP, 64'h01);
		reg_write(rwc_pkg::REG_WIDTH, 64'd5);
		reg_write(rwc_pkg::REG_HEIGHT, 64'd5);
		for (int k = 0; k < 25; k++)
			send_item((k & 1) ? 8'd255 : 8'd0, 8'(k * 10), 8'(255 - k * 10), 1'b0);
		flush_frame();
		settle();
		reg_write(rwc_pkg::REG_FIVE, 64'd0);
		reg_write(rwc_pkg::REG_TAPS_LOW, 64'hFFFF_FFFF_FFFF_FF80);
		reg_write(rwc_pkg::REG_TAPS_MID, 64'h7F7F_7F7F_7F7F_7FFF);
		send_frames(1);
		flush_frame();
		settle();
		reg_write(rwc_pkg::REG_TAPS_LOW, 64'h0000_0000_0000_0000);
		reg_write(rwc_pkg::REG_TAPS_MID, 64'h0000_0000_0000_0000);
		send_frames(1);
		// A drain inside an unfinished frame must be ignored.
		send_pixel();
		send_item(8'd0, 8'd0, 8'd0, 1'b1);
		settle();
	endtask

	// Out-of-range sizes in both directions, and a size change mid-frame.
	task automatic test_geometry_limits();
		reg_write(rwc_pkg::REG_FIVE, 64'd1);
		reg_write(rwc_pkg::REG_TAPS_LOW, 64'h0102_0304_0506_0708);
		reg_write(rwc_pkg::REG_WIDTH, 64'd0);
		reg_write(rwc_pkg::REG_HEIGHT, 64'd0);
		for (int i = 0; i < 40; i++) send_pixel();
		settle();
		reg_write(rwc_pkg::REG_WIDTH, 64'hFFF);
		reg_write(rwc_pkg::REG_HEIGHT, 64'h1FFF);
		for (int i = 0; i < 30; i++) send_pixel();
		settle();
		reg_write(rwc_pkg::REG_WIDTH, 64'd7);
		reg_write(rwc_pkg::REG_HEIGHT, 64'd6);
		for (int i = 0; i < 60; i++) send_pixel();
		settle();
	endtask

	function automatic logic [63:0] random_taps(int mode);
		logic [63:0] v;
		for (int i = 0; i < 8; i++) begin
			case (mode)
				0: v[8*i +: 8] = 8'($urandom_range(255));
				1: v[8*i +: 8] = 8'($urandom_range(3));
				2: v[8*i +: 8] = 8'd0;
				default: v[8*i +: 8] = -8'($urandom_range(2));
			endcase
		end
		return v;
	endfunction

	// Phases of random configuration, each mostly whole frames of random
	// pixels, with stray drains and now and then a frame cut short.
	task automatic test_random_frames();
		int mode, nframes, npix;
		bit pressed;
		pressed = 1'b0;
		while (items_sent < ITEM_GOAL) begin
			settle();
			mode = $urandom_range(3);
			reg_write(rwc_pkg::REG_TAPS_LOW, random_taps(mode));
			reg_write(rwc_pkg::REG_TAPS_MID, random_taps(mode));
			reg_write(rwc_pkg::REG_TAPS_HIGH, random_taps(mode));
			reg_write(rwc_pkg::REG_LAST_TAP, random_taps(mode) & 64'hFF);
			reg_write(rwc_pkg::REG_FIVE, 64'($urandom_range(1)));
			reg_write(rwc_pkg::REG_WIDTH, ($urandom_range(9) == 0)
				? 64'($urandom_range(4)) : 64'($urandom_range(5, 12)));
			reg_write(rwc_pkg::REG_HEIGHT, ($urandom_range(9) == 0)
				? 64'($urandom_range(4)) : 64'($urandom_range(5, 8)));
			quiet = ($urandom_range(7) == 0);
			nframes = $urandom_range(1, 3);
			npix = nframes * active_width() * active_height();
			for (int i = 0; i < npix; i++) begin
				if (!pressed && i == npix / 2) begin
					// The receiver holds off while pixels keep coming.
					-> hold_go;
					pressed = 1'b1;
				end
				if ($urandom_range(99) < 5)
					send_item(8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 1'b1);
				if ($urandom_range(199) == 0) break;
				send_pixel();
			end
			quiet = 1'b0;
			flush_frame();
		end
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_geometry_limits();
		test_random_frames();
		$display("Sent %0d items and checked %0d output pixels over 3x3 and 5x5 kernels,",
			items_sent, pixels_checked);
		$display("with zero, negative and random tap sums and clamped frame sizes.");
		if (errors == 0) begin
			$display("rgb_window_convolution_filter verification clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("rgb_window_convolution_filter verification failed");
		end
		$finish;
	end

endmodule
